@@ rtl/consistent_hash_ring_lookup_top_defines.svh @@
// Assertion macros shared by the ring lookup RTL.
`ifndef CONSISTENT_HASH_RING_LOOKUP_TOP_DEFINES_SVH
`define CONSISTENT_HASH_RING_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CHRL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/chrl_pkg.sv @@
package chrl_pkg;

   localparam int POINT_W     = 32;
   localparam int HOST_W      = 4;
   localparam int POS_W       = 8;
   localparam int HEALTH_W    = 16;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int ENTRIES_W   = 9;
   localparam int RETRY_W     = 9;
   localparam int HOSTCNT_W   = 5;

   // Commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOST_COUNT     = 2'd2;

   typedef struct packed {
      logic                command;
      logic [POS_W-1:0]    entry_position;
      logic [POINT_W-1:0]  entry_point;
      logic [HOST_W-1:0]   entry_host;
      logic [POINT_W-1:0]  key_hash;
      logic [HEALTH_W-1:0] healthy_hosts;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HOST_W-1:0]   host_index;
      logic [POS_W-1:0]    ring_position;
   } rsp_type;

   typedef struct packed {
      logic [POINT_W-1:0] point;
      logic [HOST_W-1:0]  owner;
   } ring_entry_type;

endpackage

@@ rtl/chrl_ram.sv @@
module chrl_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/consistent_hash_ring_lookup_top.sv @@
// Consistent-hash ring lookup.
// req channel (valid/ready): a load command writes one ring entry (point and
// owning host) at entry_position; a lookup command takes key_hash and a
// healthy_hosts mask and picks a host from the ring. Every transfer on req
// produces exactly one transfer on rsp, in order.
// csr channel (valid/ready, always ready): index 0 entries_in_use, index 1
// retry_limit, index 2 host_count. Write only while the block is idle.
// A load or an empty-ring / zero-try lookup goes straight to the output
// register. A lookup reads the first and last points, then runs
// binary-search steps (about log2 of the entry count), each a read and a
// compare, and a closing step; then it walks the ring, one read and one check
// per entry tried, and hands off through the output register. The search is
// skipped for a key outside the ring's span or a single entry. Every step is
// one access to the single read port of the ring RAM, whose read is registered.
// One item is worked at a time; the next is taken once the result sits in
// the output register, even while rsp is stalled. A stalled rsp holds its
// payload; a finished item then waits until the output register frees up.
// Reset clears the configuration registers, the sequencer state and the output
// valid; ring contents are undefined until loaded, and no clearing pass runs.
module consistent_hash_ring_lookup_top #(
   parameter int RING_DEPTH = 256,
   parameter int MAX_HOSTS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  chrl_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output chrl_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [chrl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [chrl_pkg::CSR_DATA_W-1:0]     csr_data
);

   import chrl_pkg::*;

`include "consistent_hash_ring_lookup_top_defines.svh"

   // AW addresses the ring RAM; NW holds an entry count up to RING_DEPTH.
   localparam int AW  = $clog2(RING_DEPTH);
   localparam int NW0 = $clog2(RING_DEPTH + 1);
   localparam int NW  = (NW0 > ENTRIES_W) ? NW0 : ENTRIES_W;
   localparam int EW  = POINT_W + HOST_W;

   // Sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RD_FIRST = 4'd1;
   localparam logic [3:0] S_RD_LAST  = 4'd2;
   localparam logic [3:0] S_CHK_ENDS = 4'd3;
   localparam logic [3:0] S_SRCH_RD  = 4'd4;
   localparam logic [3:0] S_SRCH_CMP = 4'd5;
   localparam logic [3:0] S_WALK_RD  = 4'd6;
   localparam logic [3:0] S_WALK_CHK = 4'd7;
   localparam logic [3:0] S_RESP     = 4'd8;

   // Configuration registers
   logic [ENTRIES_W-1:0] entries_ff;
   logic [RETRY_W-1:0]   retry_ff;
   logic [HOSTCNT_W-1:0] hosts_ff;

   // Sequencer and working registers
   logic [3:0]           state_ff, state_in;
   logic [POINT_W-1:0]   key_ff, key_in;
   logic [HEALTH_W-1:0]  health_ff, health_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [RETRY_W-1:0]   tries_ff, tries_in;
   logic [RETRY_W-1:0]   k_ff, k_in;
   logic [POINT_W-1:0]   p0_ff, p0_in;
   logic [NW-1:0]        lo_ff, lo_in;
   logic [NW-1:0]        hi_ff, hi_in;
   logic [AW-1:0]        idx_ff, idx_in;
   rsp_type              res_ff, res_in;

   // Output register
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                 req_fire;
   logic                 slot_free;
   logic [NW-1:0]        n_cfg;
   logic [RETRY_W-1:0]   tries_cfg;
   logic [NW:0]          mid_sum;
   logic [NW-1:0]        mid;
   logic [NW-1:0]        idx_next;
   logic                 owner_ok;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   ring_entry_type       wr_entry;
   ring_entry_type       rd_entry;
   logic [EW-1:0]        rd_raw;

   // ---------------------------------------------------------------------
   // Configuration port: always ready, unknown indexes dropped.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
         retry_ff   <= '0;
         hosts_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENTRIES_IN_USE: entries_ff <= ENTRIES_W'(csr_data);
            CSR_RETRY_LIMIT:    retry_ff   <= RETRY_W'(csr_data);
            CSR_HOST_COUNT:     hosts_ff   <= HOSTCNT_W'(csr_data);
            default: begin
            end
         endcase
      end
   end

   // Entry count clamps at the table depth; a retry limit of zero falls
   // back to the host count.
   assign n_cfg = (NW'(entries_ff) > NW'(RING_DEPTH)) ? NW'(RING_DEPTH) : NW'(entries_ff);
   assign tries_cfg = (retry_ff != '0) ? retry_ff : RETRY_W'(hosts_ff);

   // ---------------------------------------------------------------------
   // Ring RAM: point and owner side by side, one read and one write port.
   // ---------------------------------------------------------------------
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Drop loads that land beyond the table.
   assign wr_en    = req_fire && (req_payload.command == CMD_LOAD) &&
                     (NW'(req_payload.entry_position) < NW'(RING_DEPTH));
   assign wr_addr  = AW'(req_payload.entry_position);
   assign wr_entry = '{point: req_payload.entry_point, owner: req_payload.entry_host};

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[NW:1];

   always_comb begin
      unique case (state_ff)
         S_RD_LAST: rd_addr = AW'(n_ff - NW'(1));
         S_SRCH_RD: rd_addr = AW'(mid);
         S_WALK_RD: rd_addr = idx_ff;
         default:   rd_addr = '0;
      endcase
   end

   chrl_ram #(
      .WIDTH (EW),
      .DEPTH (RING_DEPTH)
   ) ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = rd_raw;

   // Owners at or above the host limit never count as healthy.
   assign owner_ok = (7'(rd_entry.owner) < 7'(MAX_HOSTS)) && health_ff[rd_entry.owner];
   assign idx_next = NW'(idx_ff) + NW'(1);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // Sequencer: end-point check, binary search, then the health walk.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      health_in = health_ff;
      n_in      = n_ff;
      tries_in  = tries_ff;
      k_in      = k_ff;
      p0_in     = p0_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      res_in    = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in    = req_payload.key_hash;
               health_in = req_payload.healthy_hosts;
               n_in      = n_cfg;
               tries_in  = tries_cfg;
               k_in      = '0;
               res_in    = '{status: ST_LOADED, host_index: '0, ring_position: '0};
               if (req_payload.command == CMD_LOAD) begin
                  state_in = S_RESP;
               end else if (n_cfg == '0) begin
                  res_in.status = ST_EMPTY;
                  state_in      = S_RESP;
               end else if (tries_cfg == '0) begin
                  res_in.status = ST_NONE;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_RD_FIRST;
               end
            end
         end
         S_RD_FIRST: begin
            state_in = S_RD_LAST;
         end
         S_RD_LAST: begin
            p0_in    = rd_entry.point;
            state_in = S_CHK_ENDS;
         end
         S_CHK_ENDS: begin
            // Keys outside the ring's span, or a single entry, start at 0.
            if ((n_ff == NW'(1)) || (key_ff <= p0_ff) || (key_ff > rd_entry.point)) begin
               idx_in   = '0;
               state_in = S_WALK_RD;
            end else begin
               lo_in    = '0;
               hi_in    = n_ff;
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            if ((lo_ff + NW'(1)) == hi_ff) begin
               idx_in   = (hi_ff == n_ff) ? '0 : AW'(hi_ff);
               state_in = S_WALK_RD;
            end else begin
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (key_ff <= rd_entry.point) begin
               hi_in = mid;
            end else begin
               lo_in = mid;
            end
            state_in = S_SRCH_RD;
         end
         S_WALK_RD: begin
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (owner_ok) begin
               res_in   = '{status: ST_FOUND, host_index: rd_entry.owner,
                            ring_position: POS_W'(idx_ff)};
               state_in = S_RESP;
            end else if ((k_ff + RETRY_W'(1)) == tries_ff) begin
               res_in.status = ST_NONE;
               state_in      = S_RESP;
            end else begin
               k_in     = k_ff + RETRY_W'(1);
               idx_in   = (idx_next >= n_ff) ? '0 : AW'(idx_next);
               state_in = S_WALK_RD;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      health_ff <= health_in;
      n_ff      <= n_in;
      tries_ff  <= tries_in;
      k_ff      <= k_in;
      p0_ff     <= p0_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      res_ff    <= res_in;
   end

   // ---------------------------------------------------------------------
   // Output register: load the finished result, hold it while stalled.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_RESP) && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_RESP) && slot_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `CHRL_ASSERT_NOW(a_walk_within_tries, clock, reset,
      state_ff == S_WALK_CHK, k_ff < tries_ff, "walk ran past its try count")
   `CHRL_ASSERT_NOW(a_walk_index_in_ring, clock, reset,
      state_ff == S_WALK_RD, NW'(idx_ff) < n_ff, "walk index beyond entries in use")
   `CHRL_ASSERT_NOW(a_search_mid_inside, clock, reset,
      state_ff == S_SRCH_CMP, (mid > lo_ff) && (mid < hi_ff), "search midpoint left its bounds")
   `CHRL_ASSERT_NEXT(a_found_is_healthy, clock, reset,
      (state_ff == S_WALK_CHK) && owner_ok,
      (res_ff.status == ST_FOUND) && health_ff[res_ff.host_index], "selected host not healthy")

endmodule
